// ===== design/rn_pkg.sv =====
// Shared types, constants and numeral tables for the Roman numeral core.
package rn_pkg;

  localparam int unsigned ValueW = 12;
  localparam int unsigned SymW = 8;
  localparam int unsigned TableLen = 13;
  localparam int unsigned IdxW = 4;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueueAw = 1;
  localparam int unsigned QueueCntW = 2;

  localparam logic [ValueW-1:0] MaxRoman = 12'd3999;

  localparam logic [SymW-1:0] SymNul = 8'h00;
  localparam logic [SymW-1:0] SymI = 8'h49;
  localparam logic [SymW-1:0] SymV = 8'h56;
  localparam logic [SymW-1:0] SymX = 8'h58;
  localparam logic [SymW-1:0] SymL = 8'h4C;
  localparam logic [SymW-1:0] SymC = 8'h43;
  localparam logic [SymW-1:0] SymD = 8'h44;
  localparam logic [SymW-1:0] SymM = 8'h4D;

  // One classified item as it waits between the front and the back.
  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              range_error;
  } rn_item_t;

  typedef enum logic {
    RnIdle,
    RnRun
  } rn_state_e;

  // Weight of each table row, largest first.
  function automatic logic [ValueW-1:0] rn_weight(input logic [IdxW-1:0] idx);
    logic [ValueW-1:0] w;
    unique case (idx)
      4'd0:    w = 12'd1000;
      4'd1:    w = 12'd900;
      4'd2:    w = 12'd500;
      4'd3:    w = 12'd400;
      4'd4:    w = 12'd100;
      4'd5:    w = 12'd90;
      4'd6:    w = 12'd50;
      4'd7:    w = 12'd40;
      4'd8:    w = 12'd10;
      4'd9:    w = 12'd9;
      4'd10:   w = 12'd5;
      4'd11:   w = 12'd4;
      4'd12:   w = 12'd1;
      default: w = 12'd1;
    endcase
    return w;
  endfunction

  // Leading character of each row.
  function automatic logic [SymW-1:0] rn_first(input logic [IdxW-1:0] idx);
    logic [SymW-1:0] s;
    unique case (idx)
      4'd0:    s = SymM;
      4'd1:    s = SymC;
      4'd2:    s = SymD;
      4'd3:    s = SymC;
      4'd4:    s = SymC;
      4'd5:    s = SymX;
      4'd6:    s = SymL;
      4'd7:    s = SymX;
      4'd8:    s = SymX;
      4'd9:    s = SymI;
      4'd10:   s = SymV;
      4'd11:   s = SymI;
      default: s = SymI;
    endcase
    return s;
  endfunction

  // Second character of the subtractive rows, NUL for single-character rows.
  function automatic logic [SymW-1:0] rn_second(input logic [IdxW-1:0] idx);
    logic [SymW-1:0] s;
    unique case (idx)
      4'd1:    s = SymM;
      4'd3:    s = SymD;
      4'd5:    s = SymC;
      4'd7:    s = SymL;
      4'd9:    s = SymX;
      4'd11:   s = SymV;
      default: s = SymNul;
    endcase
    return s;
  endfunction

endpackage

// ===== design/rn_front.sv =====
// Input side: accepts values, flags out-of-range ones and queues them for the emitter.
module rn_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          value_valid_i,
  input  logic [rn_pkg::ValueW-1:0]     value_i,
  output logic                          value_stall_o,
  output logic                          item_valid_o,
  output rn_pkg::rn_item_t              item_o,
  input  logic                          pop_i
);

  rn_pkg::rn_item_t              mem_q [rn_pkg::QueueDepth];
  logic [rn_pkg::QueueAw-1:0]    wr_ptr_q, wr_ptr_d;
  logic [rn_pkg::QueueAw-1:0]    rd_ptr_q, rd_ptr_d;
  logic [rn_pkg::QueueCntW-1:0]  count_q, count_d;
  logic                          push;
  logic                          pop;
  rn_pkg::rn_item_t              item_in;

  assign value_stall_o = (count_q == rn_pkg::QueueCntW'(rn_pkg::QueueDepth));
  assign item_valid_o  = (count_q != '0);
  assign item_o        = mem_q[rd_ptr_q];

  assign push = value_valid_i && !value_stall_o;
  assign pop  = pop_i && item_valid_o;

  // Classification: anything past 3999 has no numeral and only gets a flagged terminator.
  always_comb begin
    item_in.range_error = (value_i > rn_pkg::MaxRoman);
    item_in.value       = value_i;
  end

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= rn_pkg::QueueCntW'(rn_pkg::QueueDepth))
    else $error("queue fill count exceeds depth");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) || (count_q == rn_pkg::QueueCntW'(rn_pkg::QueueDepth))
      |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers disagree with fill count");

  a_pop_when_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> item_valid_o)
    else $error("item taken from an empty queue");

endmodule

// ===== design/rn_back.sv =====
// Emitter: turns one queued item into its numeral characters and a terminator.
module rn_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        item_valid_i,
  input  rn_pkg::rn_item_t            item_i,
  output logic                        pop_o,
  output logic                        result_valid_o,
  output logic [rn_pkg::SymW-1:0]     symbol_o,
  output logic                        last_o,
  output logic                        range_error_o,
  input  logic                        result_stall_i
);

  rn_pkg::rn_state_e            state_q, state_d;
  logic [rn_pkg::ValueW-1:0]    remaining_q, remaining_d;
  logic [rn_pkg::SymW-1:0]      pending_q, pending_d;
  logic                         err_q, err_d;
  logic                         out_valid_q, out_valid_d;
  logic [rn_pkg::SymW-1:0]      sym_q, sym_d;
  logic                         last_q, last_d;
  logic                         rerr_q, rerr_d;
  logic                         advance;
  logic [rn_pkg::IdxW-1:0]      sel;

  assign advance = !out_valid_q || !result_stall_i;

  // Largest table weight that still fits into what is left.
  always_comb begin
    sel = rn_pkg::IdxW'(rn_pkg::TableLen - 1);
    for (int i = rn_pkg::TableLen - 1; i >= 0; i--) begin
      if (remaining_q >= rn_pkg::rn_weight(rn_pkg::IdxW'(i))) begin
        sel = rn_pkg::IdxW'(i);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rn_pkg::RnIdle: begin
        if (item_valid_i) begin
          state_d = rn_pkg::RnRun;
        end
      end
      rn_pkg::RnRun: begin
        if (advance && pending_q == rn_pkg::SymNul && remaining_q == '0) begin
          state_d = rn_pkg::RnIdle;
        end
      end
      default: state_d = rn_pkg::RnIdle;
    endcase
  end

  always_comb begin
    pop_o       = 1'b0;
    remaining_d = remaining_q;
    pending_d   = pending_q;
    err_d       = err_q;
    out_valid_d = advance ? 1'b0 : out_valid_q;
    sym_d       = sym_q;
    last_d      = last_q;
    rerr_d      = rerr_q;
    unique case (state_q)
      rn_pkg::RnIdle: begin
        if (item_valid_i) begin
          pop_o       = 1'b1;
          remaining_d = item_i.range_error ? '0 : item_i.value;
          err_d       = item_i.range_error;
          pending_d   = rn_pkg::SymNul;
        end
      end
      rn_pkg::RnRun: begin
        if (advance) begin
          out_valid_d = 1'b1;
          last_d      = 1'b0;
          rerr_d      = 1'b0;
          if (pending_q != rn_pkg::SymNul) begin
            sym_d     = pending_q;
            pending_d = rn_pkg::SymNul;
          end else if (remaining_q == '0) begin
            sym_d  = rn_pkg::SymNul;
            last_d = 1'b1;
            rerr_d = err_q;
          end else begin
            sym_d       = rn_pkg::rn_first(sel);
            pending_d   = rn_pkg::rn_second(sel);
            remaining_d = remaining_q - rn_pkg::rn_weight(sel);
          end
        end
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rn_pkg::RnIdle;
      remaining_q <= '0;
      pending_q   <= rn_pkg::SymNul;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      remaining_q <= remaining_d;
      pending_q   <= pending_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q  <= err_d;
    sym_q  <= sym_d;
    last_q <= last_d;
    rerr_q <= rerr_d;
  end

  assign result_valid_o = out_valid_q;
  assign symbol_o       = sym_q;
  assign last_o         = last_q;
  assign range_error_o  = rerr_q;

  a_term_is_nul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && last_q |-> sym_q == rn_pkg::SymNul)
    else $error("terminator beat carries a character");

  a_err_on_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && rerr_q |-> last_q)
    else $error("range error flagged on a character beat");

  a_pending_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q != rn_pkg::SymNul |-> state_q == rn_pkg::RnRun)
    else $error("second character pending outside a run");

  a_remaining_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    remaining_q <= rn_pkg::MaxRoman)
    else $error("remaining value above numeral range");

endmodule

// ===== design/integer_to_roman_numeral_core.sv =====
// Top level of the integer to Roman numeral converter.
// Each input beat carries a 12-bit unsigned value; the core answers with the
// value's Roman numeral in standard subtractive form (IV, IX, XL, XC, CD, CM),
// one ASCII character per output beat, followed by a NUL beat with last set.
// A value of zero produces only the NUL beat. A value above 3999 produces only
// the NUL beat, with range_error_o set on it; range_error_o is always low on
// character beats. A front stage classifies incoming values and holds up to two
// of them in a queue, so new values are taken while the emitter is busy. The
// emitter handles one value at a time: it first takes the value from the queue,
// then walks the greedy weight table and gives one output beat per cycle while
// the output does not stall; the longest numeral is the fifteen characters of 3888.
// Output stall holds the emitter and its output register; the queue keeps
// filling until it is full, and then value_stall_o goes high.
module integer_to_roman_numeral_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        value_valid_i,
  input  logic [rn_pkg::ValueW-1:0]   value_i,
  output logic                        value_stall_o,
  output logic                        result_valid_o,
  output logic [rn_pkg::SymW-1:0]     symbol_o,
  output logic                        last_o,
  output logic                        range_error_o,
  input  logic                        result_stall_i
);

  // Classified value at the head of the queue, and the emitter's take strobe.
  logic             item_valid;
  rn_pkg::rn_item_t item;
  logic             item_pop;

  rn_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .value_valid_i (value_valid_i),
    .value_i       (value_i),
    .value_stall_o (value_stall_o),
    .item_valid_o  (item_valid),
    .item_o        (item),
    .pop_i         (item_pop)
  );

  rn_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (item_valid),
    .item_i         (item),
    .pop_o          (item_pop),
    .result_valid_o (result_valid_o),
    .symbol_o       (symbol_o),
    .last_o         (last_o),
    .range_error_o  (range_error_o),
    .result_stall_i (result_stall_i)
  );

endmodule

// ===== sim/integer_to_roman_numeral_core_test.sv =====
// Self-checking testbench for the integer to Roman numeral core.
module integer_to_roman_numeral_core_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ClkPeriod = 12;
  localparam int unsigned ResetCycles = 10;
  localparam int unsigned IdlePercent = 12;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned StuckLimit = 2000;
  localparam int unsigned PrintLimit = 30;

  // One output beat as the core should present it.
  typedef struct packed {
    logic [rn_pkg::SymW-1:0] symbol;
    logic                    last;
    logic                    range_error;
  } glyph_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      value_valid_i;
  logic [rn_pkg::ValueW-1:0] value_i;
  logic                      value_stall_o;
  logic                      result_valid_o;
  logic [rn_pkg::SymW-1:0]   symbol_o;
  logic                      last_o;
  logic                      range_error_o;
  logic                      result_stall_i;

  // Characters still owed by the core, oldest first, across all pending values.
  glyph_t numeral_q[$];

  int unsigned error_count = 0;
  int unsigned values_sent = 0;
  int unsigned beats_checked = 0;
  int unsigned overflow_sent = 0;
  int unsigned stuck_cycles = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  bit          quiet = 1'b0;

  integer_to_roman_numeral_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .value_valid_i (value_valid_i),
    .value_i       (value_i),
    .value_stall_o (value_stall_o),
    .result_valid_o(result_valid_o),
    .symbol_o      (symbol_o),
    .last_o        (last_o),
    .range_error_o (range_error_o),
    .result_stall_i(result_stall_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Appends the characters of one decimal digit. The digit is written with
  // the symbols for one, five and ten units of its decade, in the standard
  // subtractive form: 4 and 9 become one-five and one-ten pairs.
  task automatic push_digit(input int unsigned digit, input logic [rn_pkg::SymW-1:0] one,
                            input logic [rn_pkg::SymW-1:0] five,
                            input logic [rn_pkg::SymW-1:0] ten);
    int unsigned n;
    if (digit == 9) begin
      numeral_q.push_back('{one, 1'b0, 1'b0});
      numeral_q.push_back('{ten, 1'b0, 1'b0});
    end else if (digit == 4) begin
      numeral_q.push_back('{one, 1'b0, 1'b0});
      numeral_q.push_back('{five, 1'b0, 1'b0});
    end else begin
      if (digit >= 5) numeral_q.push_back('{five, 1'b0, 1'b0});
      for (n = 0; n < digit % 5; n++) numeral_q.push_back('{one, 1'b0, 1'b0});
    end
  endtask

  // Queues the full numeral for an accepted value, terminator included.
  // Out-of-range values and zero owe only the terminator.
  task automatic predict_numeral(input logic [rn_pkg::ValueW-1:0] v);
    if (v > rn_pkg::MaxRoman) begin
      numeral_q.push_back('{rn_pkg::SymNul, 1'b1, 1'b1});
    end else begin
      push_digit(v / 1000, rn_pkg::SymM, rn_pkg::SymNul, rn_pkg::SymNul);
      push_digit((v / 100) % 10, rn_pkg::SymC, rn_pkg::SymD, rn_pkg::SymM);
      push_digit((v / 10) % 10, rn_pkg::SymX, rn_pkg::SymL, rn_pkg::SymC);
      push_digit(v % 10, rn_pkg::SymI, rn_pkg::SymV, rn_pkg::SymX);
      numeral_q.push_back('{rn_pkg::SymNul, 1'b1, 1'b0});
    end
  endtask

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    error_count++;
    if (error_count <= PrintLimit)
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field, got,
               want);
  endtask

  // Offers one value and returns at the falling edge after it was taken.
  // The sender may idle first, except during a quiet stretch. Valid is
  // written once per falling edge, so back-to-back beats keep it high.
  task automatic send_value(input logic [rn_pkg::ValueW-1:0] v);
    while (!quiet && $urandom_range(99) < IdlePercent) begin
      value_valid_i <= 1'b0;
      value_i       <= rn_pkg::ValueW'($urandom);
      @(negedge clk_i);
    end
    value_valid_i <= 1'b1;
    value_i       <= v;
    do @(posedge clk_i); while (value_stall_o);
    predict_numeral(v);
    values_sent++;
    if (v > rn_pkg::MaxRoman) overflow_sent++;
    @(negedge clk_i);
  endtask

  // Picks a value: mostly valid numerals, with digit-built values that hit
  // the longest forms, plus zeros and out-of-range values.
  function automatic logic [rn_pkg::ValueW-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 7) return rn_pkg::ValueW'($urandom_range(4095, 4000));
    if (r < 10) return '0;
    if (r < 25)
      return rn_pkg::ValueW'($urandom_range(3) * 1000 + $urandom_range(9) * 100 +
                             $urandom_range(9) * 10 + $urandom_range(9));
    return rn_pkg::ValueW'($urandom_range(3999, 1));
  endfunction

  // Extremes of the field, every subtractive pair, zero, the out-of-range
  // edge and the longest numeral.
  task automatic test_directed();
    logic [rn_pkg::ValueW-1:0] vals[$];
    vals = '{12'd0, 12'd1, 12'd4, 12'd5, 12'd9, 12'd14, 12'd40, 12'd49, 12'd50,
             12'd90, 12'd99, 12'd400, 12'd444, 12'd500, 12'd900, 12'd999,
             12'd1994, 12'd2048, 12'd3000, 12'd3888, 12'd3999, 12'd4000,
             12'd4094, 12'd4095};
    foreach (vals[i]) send_value(vals[i]);
  endtask

  // Neither side idles, so values arrive back to back at full rate.
  task automatic test_full_rate();
    quiet = 1'b1;
    repeat (25) send_value(pick_value());
    quiet = 1'b0;
  endtask

  // The receiver holds off for a long stretch while values keep coming,
  // so the queue fills and the core must stall its input.
  task automatic test_backpressure();
    hold_requests++;
    repeat (10) send_value(rn_pkg::ValueW'($urandom_range(3999, 3000)));
  endtask

  task automatic test_random();
    repeat (130) send_value(pick_value());
  endtask

  // Receiver side: random stall, none in a quiet stretch, and a long
  // counted hold whenever a test asks for one.
  initial begin
    result_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_requests != hold_served) begin
        hold_served++;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall_i <= 1'b1;
      end else if (quiet) begin
        result_stall_i <= 1'b0;
      end else begin
        result_stall_i <= ($urandom_range(99) < IdlePercent);
      end
    end
  end

  // Every output beat is matched against the oldest owed character.
  always @(posedge clk_i) begin
    glyph_t want;
    if (rst_ni && result_valid_o && !result_stall_i) begin
      beats_checked++;
      if (numeral_q.size() == 0) begin
        report_mismatch("unexpected beat symbol", symbol_o, 0);
      end else begin
        want = numeral_q.pop_front();
        if (symbol_o !== want.symbol) report_mismatch("symbol", symbol_o, want.symbol);
        if (last_o !== want.last) report_mismatch("last", last_o, want.last);
        if (range_error_o !== want.range_error)
          report_mismatch("range_error", range_error_o, want.range_error);
      end
    end
  end

  // Ends the run if neither channel moves a beat for too long.
  always @(posedge clk_i) begin
    if ((value_valid_i && !value_stall_o) || (result_valid_o && !result_stall_i)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles + 1 >= StuckLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    value_valid_i = 1'b0;
    value_i       = '0;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_full_rate();
    test_backpressure();
    test_random();

    value_valid_i <= 1'b0;
    while (numeral_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Converted %0d values (%0d out of range), checked %0d output beats,",
             values_sent, overflow_sent, beats_checked);
    $display("including a full-rate stretch and a long output hold-off.");
    if (error_count == 0 && numeral_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/rn_pkg.sv
design/rn_front.sv
design/rn_back.sv
design/integer_to_roman_numeral_core.sv
sim/integer_to_roman_numeral_core_test.sv
